/* design/gf2pd_pkg.sv */
// Shared types for the GF(2) polynomial divider.
package gf2pd_pkg;

   localparam int unsigned WORD_BITS = 64;

   typedef struct packed {
      logic [WORD_BITS-1:0] dividend_poly;
      logic [WORD_BITS-1:0] divisor_poly;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] quotient_poly;
      logic [WORD_BITS-1:0] remainder_poly;
      logic                 zero_divisor;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NORM,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic norm_shift;
      logic div_step;
   } cmd_type;

   typedef struct packed {
      logic zero_div;
      logic div_msb;
      logic count_zero;
   } status_type;

endpackage

/* design/gf2pd_dpath.sv */
// Datapath of the GF(2) divider: operand registers, normalize shifter, XOR step.
module gf2pd_dpath #(
   parameter int unsigned POLY_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  gf2pd_pkg::req_type  req_item,
   input  gf2pd_pkg::cmd_type  cmd,
   output gf2pd_pkg::status_type status,
   output gf2pd_pkg::rsp_type  rsp_item
);
   import gf2pd_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(POLY_BITS);

   logic [POLY_BITS-1:0] div_ff, div_in;
   logic [POLY_BITS-1:0] rem_ff, rem_in;
   logic [POLY_BITS-1:0] quot_ff, quot_in;
   logic [POLY_BITS-1:0] mask_ff, mask_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 zero_ff, zero_in;
   logic                 hit;

   // Quotient bit: remainder holds the term that the aligned divisor leads with.
   assign hit = |(rem_ff & mask_ff);

   always_comb begin
      div_in   = div_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      mask_in  = mask_ff;
      count_in = count_ff;
      zero_in  = zero_ff;
      if (cmd.load) begin
         div_in   = req_item.divisor_poly[POLY_BITS-1:0];
         rem_in   = req_item.dividend_poly[POLY_BITS-1:0];
         quot_in  = '0;
         mask_in  = {1'b1, {(POLY_BITS-1){1'b0}}};
         count_in = '0;
         zero_in  = (req_item.divisor_poly[POLY_BITS-1:0] == '0);
      end else if (cmd.norm_shift) begin
         div_in   = {div_ff[POLY_BITS-2:0], 1'b0};
         count_in = count_ff + 1'b1;
      end else if (cmd.div_step) begin
         if (hit) begin
            rem_in = rem_ff ^ div_ff;
         end
         quot_in  = {quot_ff[POLY_BITS-2:0], hit};
         div_in   = {1'b0, div_ff[POLY_BITS-1:1]};
         mask_in  = {1'b0, mask_ff[POLY_BITS-1:1]};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         zero_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         zero_ff  <= zero_in;
      end
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      mask_ff <= mask_in;
   end

   assign status.zero_div   = zero_ff;
   assign status.div_msb    = div_ff[POLY_BITS-1];
   assign status.count_zero = (count_ff == '0);

   assign rsp_item.quotient_poly  = WORD_BITS'(quot_ff);
   assign rsp_item.remainder_poly = WORD_BITS'(rem_ff);
   assign rsp_item.zero_divisor   = zero_ff;

endmodule

/* design/gf2pd_ctrl.sv */
// Controller state machine of the GF(2) divider.
module gf2pd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  gf2pd_pkg::status_type status,
   output gf2pd_pkg::cmd_type    cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import gf2pd_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.zero_div) state_in = ST_DONE;
            else if (status.div_msb) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.count_zero) state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_NORM: begin
            // shift the divisor up until its leading term sits in the top bit
            cmd.norm_shift = !status.zero_div && !status.div_msb;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/gf2_polynomial_divide_core.sv */
// GF(2) polynomial divider, top level.
// A request is taken when start is high and busy is low; the operands are cut to their
// low POLY_BITS bits. The block first shifts the divisor up one bit per cycle until its
// leading term is in the top bit (k shifts, k = POLY_BITS-1-degree of divisor), then
// runs k+1 long-division steps, one quotient bit per cycle, and finally shows the result
// for one cycle with rsp_valid. A zero divisor goes straight to the result and returns
// quotient 0, the dividend as remainder and zero_divisor set. busy is low only in the
// idle state, in which a request is taken, and high in every later state through
// the strobe cycle. The result is present for that single cycle
// only: the receiver cannot stall it and must take it then.
module gf2_polynomial_divide_core #(
   parameter int unsigned POLY_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gf2pd_pkg::req_type req_item,
   output logic               rsp_valid,
   output gf2pd_pkg::rsp_type rsp_item
);
   import gf2pd_pkg::*;

   cmd_type    cmd;
   status_type status;

   gf2pd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   gf2pd_dpath #(
      .POLY_BITS (POLY_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
